>>> src/qesg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qesg_pkg: shared types and constants
// Register map, reset values and the state, configuration and result
// structures of the quadrature encoder signal generator.
// ----------------------------------------------------------------------------
package qesg_pkg;

  localparam int unsigned PeriodW  = 24;
  localparam int unsigned EveryW   = 16;
  localparam int unsigned ElapsedW = PeriodW + 1;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;

  // Register indexes (word address bits [3:2]).
  localparam logic [1:0] REG_HALF_PERIOD  = 2'd0;
  localparam logic [1:0] REG_PHASE_OFFSET = 2'd1;
  localparam logic [1:0] REG_INDEX_WIDTH  = 2'd2;
  localparam logic [1:0] REG_INDEX_EVERY  = 2'd3;

  localparam logic [PeriodW-1:0] HalfPeriodRst  = PeriodW'(7200 / 2);
  localparam logic [PeriodW-1:0] PhaseOffsetRst = PeriodW'(7200 / 2);
  localparam logic [PeriodW-1:0] IndexWidthRst  = PeriodW'(7200);
  localparam logic [EveryW-1:0]  IndexEveryRst  = EveryW'(1300);

  localparam logic [ElapsedW-1:0] ElapsedMax = '1;

  typedef struct packed {
    logic [PeriodW-1:0] half_period;
    logic [PeriodW-1:0] phase_offset;
    logic [PeriodW-1:0] index_width;
    logic [EveryW-1:0]  index_every;
  } qesg_cfg_t;

  typedef struct packed {
    logic [ElapsedW-1:0] wave_elapsed;
    logic [ElapsedW-1:0] index_elapsed;
    logic                level_a;
    logic                level_b;
    logic                a_armed;
    logic [EveryW-1:0]   edge_count;
    logic                index_active;
    logic                level_z;
  } qesg_state_t;

  typedef struct packed {
    logic              enc_a;
    logic              enc_b;
    logic              enc_z;
    logic [EveryW-1:0] edges_seen;
  } qesg_result_t;

endpackage

>>> src/qesg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qesg_core: next-state logic for one time-base tick
// Computes the updated waveform and index state from the current state, the
// configuration and the advance flag.
// ----------------------------------------------------------------------------
module qesg_core import qesg_pkg::*; (
  input  qesg_cfg_t   cfg_i,
  input  qesg_state_t state_i,
  input  logic        advance_i,
  output qesg_state_t state_o
);

  logic [ElapsedW-1:0] wave_inc;
  logic [ElapsedW-1:0] index_inc;
  logic [ElapsedW-1:0] b_limit;
  qesg_state_t         s;

  assign wave_inc  = (state_i.wave_elapsed == ElapsedMax) ? ElapsedMax
                                                          : state_i.wave_elapsed + 1'b1;
  assign index_inc = (state_i.index_elapsed == ElapsedMax) ? ElapsedMax
                                                           : state_i.index_elapsed + 1'b1;
  assign b_limit   = {1'b0, cfg_i.half_period} + {1'b0, cfg_i.phase_offset};

  always_comb begin
    s = state_i;
    if (advance_i) begin
      s.wave_elapsed = wave_inc;
      if ((wave_inc >= {1'b0, cfg_i.half_period}) && state_i.a_armed) begin
        s.level_a = ~state_i.level_a;
        s.a_armed = 1'b0;
      end
      if (wave_inc >= b_limit) begin
        s.level_b      = ~state_i.level_b;
        s.wave_elapsed = '0;
        s.a_armed      = 1'b1;
        s.edge_count   = state_i.edge_count + 1'b1;
      end
      // The pulse shows high only from the tick after it was started.
      if (state_i.index_active) begin
        s.level_z       = 1'b1;
        s.index_elapsed = index_inc;
        if (index_inc >= {1'b0, cfg_i.index_width}) begin
          s.level_z      = 1'b0;
          s.index_active = 1'b0;
        end
      end
      if (s.edge_count >= cfg_i.index_every) begin
        s.edge_count    = '0;
        s.index_active  = 1'b1;
        s.index_elapsed = '0;
      end
    end
    state_o = s;
  end

endmodule

>>> src/quadrature_encoder_signal_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_encoder_signal_generator_top: incremental encoder emulator
// Produces quadrature A/B levels and an index pulse Z from a stream of
// time-base ticks, with an APB register port for timing.
// ----------------------------------------------------------------------------
// Every input beat carries one advance flag and produces exactly one output
// beat with the A, B and Z levels and the B edge count after that tick. A
// beat with advance low leaves the state untouched and repeats the levels.
// The block takes one beat per clock while in_stall_o is low: the update
// is a few 25-bit increments and compares between the state registers
// and an output register, so every result leaves registered. A two-entry
// output stage (output register plus skid register) lets the next
// beat in while a finished one still waits; in_stall_o rises only when both
// entries hold beats. Registers: half_period at 0x0, phase_offset at 0x4,
// index_width at 0x8, index_every at 0xC. Write them only while the block is
// idle. The elapsed counters saturate at 2^25-1 rather than wrapping.
// ----------------------------------------------------------------------------
module quadrature_encoder_signal_generator_top import qesg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Tick input channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              advance_i,
  // Result channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              enc_a_o,
  output logic              enc_b_o,
  output logic              enc_z_o,
  output logic [EveryW-1:0] edges_seen_o,
  // Register port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  qesg_cfg_t    cfg_q;
  qesg_state_t  state_q, state_d;
  qesg_result_t result_d;
  qesg_result_t out_q, skid_q;
  logic         out_valid_q, skid_valid_q;
  logic         in_fire, out_fire, cfg_write;
  logic [1:0]   reg_sel;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period  <= HalfPeriodRst;
      cfg_q.phase_offset <= PhaseOffsetRst;
      cfg_q.index_width  <= IndexWidthRst;
      cfg_q.index_every  <= IndexEveryRst;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_HALF_PERIOD:  cfg_q.half_period  <= pwdata[PeriodW-1:0];
        REG_PHASE_OFFSET: cfg_q.phase_offset <= pwdata[PeriodW-1:0];
        REG_INDEX_WIDTH:  cfg_q.index_width  <= pwdata[PeriodW-1:0];
        REG_INDEX_EVERY:  cfg_q.index_every  <= pwdata[EveryW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HALF_PERIOD:  prdata = DataW'(cfg_q.half_period);
      REG_PHASE_OFFSET: prdata = DataW'(cfg_q.phase_offset);
      REG_INDEX_WIDTH:  prdata = DataW'(cfg_q.index_width);
      REG_INDEX_EVERY:  prdata = DataW'(cfg_q.index_every);
      default:          prdata = '0;
    endcase
  end

  // Tick update. The state advances as soon as a beat is accepted.
  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_q && !out_stall_i;

  qesg_core u_core (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .advance_i(advance_i),
    .state_o  (state_d)
  );

  assign result_d.enc_a      = state_d.level_a;
  assign result_d.enc_b      = state_d.level_b;
  assign result_d.enc_z      = state_d.level_z;
  assign result_d.edges_seen = state_d.edge_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.wave_elapsed  <= '0;
      state_q.index_elapsed <= '0;
      state_q.level_a       <= 1'b1;
      state_q.level_b       <= 1'b1;
      state_q.a_armed       <= 1'b1;
      state_q.edge_count    <= '0;
      state_q.index_active  <= 1'b0;
      state_q.level_z       <= 1'b0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Output register with a skid entry. The input is stalled only while the
  // skid entry is occupied, so a new beat can enter while one waits.
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= result_d;
      end else begin
        out_q <= result_d;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign enc_a_o      = out_q.enc_a;
  assign enc_b_o      = out_q.enc_b;
  assign enc_z_o      = out_q.enc_z;
  assign edges_seen_o = out_q.edges_seen;

endmodule
